### rtl/bcmt_pkg.sv
// Shared types, constants and helpers for the balanced class member table.
`timescale 1ns / 1ps

package bcmt_pkg;

  // Table geometry
  localparam int NUM_CLASSES     = 4;
  localparam int SLOTS_PER_CLASS = 16;
  localparam int ID_BITS         = 32;

  localparam int STORE_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int SLOT_CW     = $clog2(SLOTS_PER_CLASS + 1);

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CLS_W-1:0]   cls_t;
  typedef logic [SLOT_CW-1:0] slot_cnt_t;

  // Command codes
  localparam logic [1:0] MODE_CREATE  = 2'd0;
  localparam logic [1:0] MODE_DESTROY = 2'd1;
  localparam logic [1:0] MODE_CYCLE   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  // Border colors per class
  localparam logic [23:0] CLASS_COLOR_0 = 24'd11169350;
  localparam logic [23:0] CLASS_COLOR_1 = 24'd5208386;
  localparam logic [23:0] CLASS_COLOR_2 = 24'd16494290;
  localparam logic [23:0] CLASS_COLOR_3 = 24'd4014460;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_FETCH,
    ST_RESP
  } state_t;

  // One write port and one read port per cycle
  typedef struct packed {
    logic  we;
    addr_t waddr;
    id_t   wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  // Flat store address of a slot within a class
  function automatic addr_t slot_addr(cls_t cls, slot_cnt_t slot);
    int a;
    a = int'(cls) * SLOTS_PER_CLASS + int'(slot);
    return ADDR_W'(a);
  endfunction

  // Fixed border color; classes beyond the palette get black
  function automatic logic [23:0] class_color(cls_t cls);
    logic [23:0] c;
    case (int'(cls))
      0: c = CLASS_COLOR_0;
      1: c = CLASS_COLOR_1;
      2: c = CLASS_COLOR_2;
      3: c = CLASS_COLOR_3;
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/bcmt_id_ram.sv
// Member id store: one write and one registered read per cycle.
`timescale 1ns / 1ps

module bcmt_id_ram import bcmt_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output id_t      rd_data
);

  id_t mem_r [STORE_DEPTH];
  id_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/balanced_class_member_table.sv
// Top level: command sequencer, class counts and result register.
`timescale 1ns / 1ps

// Balanced class member table. A command is taken when start is high and
// busy is low; its single result appears for exactly one cycle with
// out_valid high and must be captured then, since there is no backpressure.
// One command is worked on at a time. Create and the unused mode finish in
// the dispatch state, as does a cycle command on an empty class. Destroy
// walks the classes in order, reading one stored id per cycle and draining
// any pending read before it leaves a class, then closes the gap at one
// slot per cycle while the rest of the class is read. Cycle reads the
// chosen class one slot per cycle and then fetches the picked member. The
// single read port of the id store sets these rates. The store is not
// cleared at reset; only slots below a class's count are ever read.
module balanced_class_member_table import bcmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_item_id,
  input  logic [1:0]  in_class_sel,
  input  logic [31:0] in_current_focus,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_member_class,
  output logic [23:0] out_border_pixel,
  output logic        out_focus_valid,
  output logic [31:0] out_focus_id
);

  state_t    state_r, state_nxt;
  slot_cnt_t count_r [NUM_CLASSES];
  slot_cnt_t count_nxt [NUM_CLASSES];

  // captured command
  logic [1:0] mode_r, mode_nxt;
  id_t        id_r, id_nxt;
  logic [1:0] sel_r, sel_nxt;
  id_t        focus_r, focus_nxt;

  // scan / shift bookkeeping
  cls_t      scan_c_r, scan_c_nxt;
  slot_cnt_t scan_k_r, scan_k_nxt;
  logic      pend_v_r, pend_v_nxt;
  slot_cnt_t pend_k_r, pend_k_nxt;
  slot_cnt_t wr_j_r, wr_j_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [1:0]  mclass_r, mclass_nxt;
  logic [23:0] pixel_r, pixel_nxt;
  logic        fvalid_r, fvalid_nxt;
  logic [31:0] fid_r, fid_nxt;

  ram_req_t ram_req;
  id_t      rd_data;

  // least-filled class, lowest index on a tie
  cls_t      best;
  slot_cnt_t cnt_cur;
  slot_cnt_t k_inc;
  logic      exhausted;
  id_t       match_id;

  always_comb begin
    best = '0;
    for (int c = 1; c < NUM_CLASSES; c++) begin
      if (count_r[c] < count_r[best]) begin
        best = CLS_W'(c);
      end
    end
  end

  assign cnt_cur   = count_r[scan_c_r];
  assign exhausted = (scan_k_r >= cnt_cur);
  assign k_inc     = pend_k_r + SLOT_CW'(1);
  assign match_id  = (mode_r == MODE_CYCLE) ? focus_r : id_r;

  bcmt_id_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        count_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      count_r     <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    id_r     <= id_nxt;
    sel_r    <= sel_nxt;
    focus_r  <= focus_nxt;
    scan_c_r <= scan_c_nxt;
    scan_k_r <= scan_k_nxt;
    pend_k_r <= pend_k_nxt;
    wr_j_r   <= wr_j_nxt;
    status_r <= status_nxt;
    mclass_r <= mclass_nxt;
    pixel_r  <= pixel_nxt;
    fvalid_r <= fvalid_nxt;
    fid_r    <= fid_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    id_nxt        = id_r;
    sel_nxt       = sel_r;
    focus_nxt     = focus_r;
    scan_c_nxt    = scan_c_r;
    scan_k_nxt    = scan_k_r;
    pend_v_nxt    = pend_v_r;
    pend_k_nxt    = pend_k_r;
    wr_j_nxt      = wr_j_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STAT_OK;
    mclass_nxt    = 2'd0;
    pixel_nxt     = 24'd0;
    fvalid_nxt    = 1'b0;
    fid_nxt       = 32'd0;
    ram_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          id_nxt    = ID_BITS'(in_item_id);
          sel_nxt   = in_class_sel;
          focus_nxt = ID_BITS'(in_current_focus);
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        case (mode_r)
          MODE_CREATE: begin
            out_valid_nxt = 1'b1;
            mclass_nxt    = 2'(best);
            state_nxt     = ST_IDLE;
            if (count_r[best] >= SLOT_CW'(SLOTS_PER_CLASS)) begin
              status_nxt = STAT_FULL;
            end else begin
              ram_req.we      = 1'b1;
              ram_req.waddr   = slot_addr(best, count_r[best]);
              ram_req.wdata   = id_r;
              count_nxt[best] = count_r[best] + SLOT_CW'(1);
              pixel_nxt       = class_color(best);
              fvalid_nxt      = 1'b1;
              fid_nxt         = 32'(id_r);
            end
          end
          MODE_DESTROY: begin
            scan_c_nxt = '0;
            scan_k_nxt = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end
          MODE_CYCLE: begin
            if (int'(sel_r) >= NUM_CLASSES || count_r[CLS_W'(sel_r)] == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt    = STAT_EMPTY;
              mclass_nxt    = sel_r;
              state_nxt     = ST_IDLE;
            end else begin
              scan_c_nxt = CLS_W'(sel_r);
              scan_k_nxt = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_SCAN;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        endcase
      end

      // read slots one per cycle, compare the previous read
      ST_SCAN: begin
        if (pend_v_r && rd_data == match_id) begin
          pend_v_nxt = 1'b0;
          if (mode_r == MODE_CYCLE) begin
            scan_k_nxt = (k_inc < cnt_cur) ? k_inc : '0;
            state_nxt  = ST_FETCH;
          end else begin
            wr_j_nxt   = pend_k_r;
            scan_k_nxt = k_inc;
            state_nxt  = ST_SHIFT;
          end
        end else if (!exhausted) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = slot_addr(scan_c_r, scan_k_r);
          pend_v_nxt    = 1'b1;
          pend_k_nxt    = scan_k_r;
          scan_k_nxt    = scan_k_r + SLOT_CW'(1);
        end else if (pend_v_r) begin
          // last read missed; let it drain
          pend_v_nxt = 1'b0;
        end else if (mode_r == MODE_CYCLE) begin
          // focus not in class: take the first member
          scan_k_nxt = '0;
          state_nxt  = ST_FETCH;
        end else if (scan_c_r == CLS_W'(NUM_CLASSES - 1)) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_NOT_FOUND;
          state_nxt     = ST_IDLE;
        end else begin
          scan_c_nxt = scan_c_r + CLS_W'(1);
          scan_k_nxt = '0;
        end
      end

      // close the gap: read slot k, write it to slot k-1 next cycle
      ST_SHIFT: begin
        if (pend_v_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = slot_addr(scan_c_r, wr_j_r);
          ram_req.wdata = rd_data;
          wr_j_nxt      = wr_j_r + SLOT_CW'(1);
        end
        if (!exhausted) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = slot_addr(scan_c_r, scan_k_r);
          scan_k_nxt    = scan_k_r + SLOT_CW'(1);
          pend_v_nxt    = 1'b1;
        end else begin
          pend_v_nxt = 1'b0;
          if (!pend_v_r) begin
            count_nxt[scan_c_r] = cnt_cur - SLOT_CW'(1);
            out_valid_nxt       = 1'b1;
            mclass_nxt          = 2'(scan_c_r);
            state_nxt           = ST_IDLE;
          end
        end
      end

      ST_FETCH: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = slot_addr(scan_c_r, scan_k_r);
        state_nxt     = ST_RESP;
      end

      ST_RESP: begin
        out_valid_nxt = 1'b1;
        mclass_nxt    = 2'(scan_c_r);
        fvalid_nxt    = 1'b1;
        fid_nxt       = 32'(rd_data);
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_member_class = mclass_r;
  assign out_border_pixel = pixel_r;
  assign out_focus_valid  = fvalid_r;
  assign out_focus_id     = fid_r;

  // a result lands as the sequencer returns to idle
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted command always occupies the sequencer next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted command did not start");

  // the store is written only on create or while closing a gap
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == ST_DISPATCH || state_r == ST_SHIFT))
    else $error("store write outside create or shift");

  // counts never pass the class capacity
  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cnt_chk
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r[g] <= SLOT_CW'(SLOTS_PER_CLASS))
      else $error("class count above capacity");
  end

endmodule

### tb/sv/member_table_checker.sv
// Checker for the balanced class member table: predicts each reply and compares it.
`timescale 1ns / 1ps

module member_table_checker import bcmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_item_id,
  input  logic [1:0]  in_class_sel,
  input  logic [31:0] in_current_focus,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [1:0]  out_member_class,
  input  logic [23:0] out_border_pixel,
  input  logic        out_focus_valid,
  input  logic [31:0] out_focus_id,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    cls_t        cls;
    logic [23:0] pixel;
    logic        fv;
    id_t         fid;
  } table_reply_t;

  localparam logic [23:0] BORDER [4] = '{CLASS_COLOR_0, CLASS_COLOR_1,
                                         CLASS_COLOR_2, CLASS_COLOR_3};

  // Shadow copy of the member lists
  id_t roster [NUM_CLASSES][SLOTS_PER_CLASS];
  int  roster_len [NUM_CLASSES];

  table_reply_t replies_due[$];
  int           errors = 0;

  // Apply one command to the shadow lists and return the reply it must produce
  function automatic table_reply_t apply_command(logic [1:0] mode, id_t id,
                                                 logic [1:0] sel, id_t focus);
    table_reply_t r;
    int best;
    int n;
    int pick;
    bit hit;
    r = '0;
    case (mode)
      MODE_CREATE: begin
        best = 0;
        for (int c = 1; c < NUM_CLASSES; c++)
          if (roster_len[c] < roster_len[best]) best = c;
        r.cls = cls_t'(best);
        if (roster_len[best] >= SLOTS_PER_CLASS) begin
          r.status = STAT_FULL;
        end else begin
          roster[best][roster_len[best]] = id;
          roster_len[best]++;
          r.status = STAT_OK;
          r.pixel  = (best < 4) ? BORDER[best] : 24'd0;
          r.fv     = 1'b1;
          r.fid    = id;
        end
      end
      MODE_DESTROY: begin
        r.status = STAT_NOT_FOUND;
        hit = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          n = roster_len[c];
          for (int k = 0; k < n; k++) begin
            if (roster[c][k] == id) begin
              // close the gap, keeping order
              for (int j = k; j + 1 < n; j++) roster[c][j] = roster[c][j+1];
              roster_len[c] = n - 1;
              r.status = STAT_OK;
              r.cls    = cls_t'(c);
              hit      = 1'b1;
              break;
            end
          end
          if (hit) break;
        end
      end
      MODE_CYCLE: begin
        r.cls = sel;
        if (int'(sel) >= NUM_CLASSES || roster_len[sel] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          n = roster_len[sel];
          pick = 0;
          for (int k = 0; k < n; k++) begin
            if (roster[sel][k] == focus) begin
              pick = (k + 1 < n) ? k + 1 : 0;
              break;
            end
          end
          r.status = STAT_OK;
          r.fv     = 1'b1;
          r.fid    = roster[sel][pick];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic check_field(string field, longint unsigned exp_v,
                             longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endtask

  // Compare replies first, then record the command taken on this edge
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) roster_len[c] = 0;
      replies_due.delete();
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply, expected none, actual status %0d class %0d",
                   $time, out_status, out_member_class);
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("member_class", want.cls, out_member_class);
          check_field("border_pixel", want.pixel, out_border_pixel);
          check_field("focus_valid", want.fv, out_focus_valid);
          check_field("focus_id", want.fid, out_focus_id);
        end
      end
      if (start && !busy)
        replies_due.push_back(apply_command(in_mode, in_item_id, in_class_sel,
                                            in_current_focus));
    end
    fail_count <= errors;
    pending    <= replies_due.size();
  end

endmodule

### tb/sv/testbench.sv
// Top of the testbench: clock, reset, command stimulus and final verdict.
`timescale 1ns / 1ps

module testbench;
  import bcmt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 600;
  localparam int TABLE_SLOTS   = NUM_CLASSES * SLOTS_PER_CLASS;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_item_id = '0;
  logic [1:0]  in_class_sel = '0;
  logic [31:0] in_current_focus = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [1:0]  out_member_class;
  logic [23:0] out_border_pixel;
  logic        out_focus_valid;
  logic [31:0] out_focus_id;
  int          fail_count;
  int          pending;

  int          cycle_count = 0;
  int          idle_pct = 0;
  id_t         live_ids[$];
  int          n_create = 0, n_destroy = 0, n_cycle = 0, n_unused = 0;
  int          n_full_try = 0, n_miss = 0, n_filled = 0;

  balanced_class_member_table DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_item_id(in_item_id), .in_class_sel(in_class_sel),
    .in_current_focus(in_current_focus),
    .out_valid(out_valid), .out_status(out_status),
    .out_member_class(out_member_class), .out_border_pixel(out_border_pixel),
    .out_focus_valid(out_focus_valid), .out_focus_id(out_focus_id)
  );

  member_table_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_item_id(in_item_id), .in_class_sel(in_class_sel),
    .in_current_focus(in_current_focus),
    .out_valid(out_valid), .out_status(out_status),
    .out_member_class(out_member_class), .out_border_pixel(out_border_pixel),
    .out_focus_valid(out_focus_valid), .out_focus_id(out_focus_id),
    .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Drive one transaction, with random idle cycles ahead of it
  task automatic send(logic [1:0] mode, id_t id, logic [1:0] sel, id_t focus);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_mode          <= mode;
    in_item_id       <= id;
    in_class_sel     <= sel;
    in_current_focus <= focus;
    do @(posedge clk); while (busy);
  endtask

  // Track which ids are live so destroy and cycle can aim at real members
  task automatic issue(logic [1:0] mode, id_t id, logic [1:0] sel, id_t focus);
    int idx;
    idx = -1;
    case (mode)
      MODE_CREATE: begin
        n_create++;
        if (live_ids.size() >= TABLE_SLOTS) begin
          n_full_try++;
        end else begin
          live_ids.push_back(id);
          if (live_ids.size() == TABLE_SLOTS) n_filled++;
        end
      end
      MODE_DESTROY: begin
        n_destroy++;
        for (int i = 0; i < live_ids.size(); i++)
          if (idx < 0 && live_ids[i] == id) idx = i;
        if (idx < 0) n_miss++;
        else live_ids.delete(idx);
      end
      MODE_CYCLE: n_cycle++;
      default: n_unused++;
    endcase
    send(mode, id, sel, focus);
  endtask

  function automatic id_t pick_live();
    return live_ids[$urandom_range(live_ids.size() - 1)];
  endfunction

  function automatic id_t edge_id();
    return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  initial begin
    int  r;
    int  done;
    bit  growing;
    id_t id;
    id_t focus;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extreme ids, duplicates, wraparound, misses
    issue(MODE_CYCLE,   32'h0,         2'd0, 32'h0);
    issue(MODE_CYCLE,   32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
    issue(MODE_DESTROY, 32'h0,         2'd0, 32'h0);
    issue(MODE_UNUSED,  32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
    issue(MODE_CREATE,  32'h0,         2'd0, 32'h0);
    issue(MODE_CREATE,  32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
    issue(MODE_CREATE,  32'h1234_5678, 2'd1, 32'h0);
    issue(MODE_CREATE,  32'hA5A5_A5A5, 2'd2, 32'h0);
    issue(MODE_CREATE,  32'h0,         2'd0, 32'h0);
    issue(MODE_CYCLE,   32'h0,         2'd0, 32'h0);
    issue(MODE_CYCLE,   32'h0,         2'd1, 32'hFFFF_FFFF);
    issue(MODE_CYCLE,   32'h0,         2'd2, 32'hDEAD_BEEF);
    issue(MODE_CREATE,  32'h5A5A_5A5A, 2'd0, 32'h0);
    issue(MODE_CYCLE,   32'h0,         2'd1, 32'h5A5A_5A5A);
    issue(MODE_CYCLE,   32'h0,         2'd1, 32'hFFFF_FFFF);
    issue(MODE_CYCLE,   32'h0,         2'd3, 32'hA5A5_A5A5);
    issue(MODE_DESTROY, 32'h0,         2'd0, 32'h0);
    issue(MODE_DESTROY, 32'h1234_5678, 2'd0, 32'h0);
    issue(MODE_CYCLE,   32'h0,         2'd2, 32'h1234_5678);
    issue(MODE_DESTROY, 32'hCAFE_F00D, 2'd0, 32'h0);
    issue(MODE_DESTROY, 32'hFFFF_FFFF, 2'd0, 32'h0);
    issue(MODE_CYCLE,   32'h0,         2'd1, 32'h0);
    issue(MODE_UNUSED,  32'h0,         2'd0, 32'h0);

    // Random: swing the table between empty and full, three idling profiles
    growing = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 53 : 0;
      done = 0;
      while (done < PHASE_ITEMS) begin
        if (growing && live_ids.size() == TABLE_SLOTS && $urandom_range(3) == 0)
          growing = 1'b0;
        else if (!growing && live_ids.size() == 0 && $urandom_range(3) == 0)
          growing = 1'b1;
        else if ($urandom_range(149) == 0)
          growing = !growing;

        r = $urandom_range(99);
        if (growing ? (r < 55) : (r < 15)) begin
          r = $urandom_range(99);
          if (r < 10 && live_ids.size() > 0) id = pick_live();
          else if (r < 14) id = edge_id();
          else id = $urandom;
          issue(MODE_CREATE, id, 2'($urandom), $urandom);
          done++;
        end else if (growing ? (r < 70) : (r < 60)) begin
          if (live_ids.size() > 0 && $urandom_range(99) < 85) id = pick_live();
          else id = $urandom;
          issue(MODE_DESTROY, id, 2'($urandom), $urandom);
          done++;
        end else if (r < 95) begin
          r = $urandom_range(99);
          if (r < 55 && live_ids.size() > 0) focus = pick_live();
          else if (r < 70) focus = edge_id();
          else focus = $urandom;
          issue(MODE_CYCLE, $urandom, 2'($urandom_range(3)), focus);
          done++;
        end else begin
          issue(MODE_UNUSED, $urandom, 2'($urandom), $urandom);
          done++;
        end
      end
    end

    // Drain: let every reply arrive, then keep clocking to catch any stray reply
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);

    $display("Ran %0d creates (%0d on a full table), %0d destroys (%0d of absent ids),",
             n_create, n_full_try, n_destroy, n_miss);
    $display("%0d cycles, %0d unused-mode commands; table filled %0d times",
             n_cycle, n_unused, n_filled);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
